// File: src/cab_blit_pkg.sv
// Shared types and constants for the clipped alpha blend blitter.
// No dependencies; imported by the top level.
`default_nettype none

package cab_blit_pkg;

    localparam int MAX_ICON_SIDE = 64;
    localparam int COORD_BITS    = 12;

    localparam int CNT_BITS   = $clog2(MAX_ICON_SIDE);
    localparam int SIDE_BITS  = 7;
    localparam int POS_BITS   = 13;
    localparam int XY_BITS    = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int FRAME_TOP  = 1 << COORD_BITS;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ICON_SIDE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd4;

    localparam logic [SIDE_BITS-1:0] ICON_SIDE_RESET    = 7'd32;
    localparam logic [POS_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd1024;
    localparam logic [POS_BITS-1:0]  FRAME_HEIGHT_RESET = 13'd768;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [31:0] source_pixel;
        logic [23:0] dest_pixel;
    } in_item_t;

    typedef struct packed {
        logic               write_enable;
        logic [XY_BITS-1:0] pixel_x;
        logic [XY_BITS-1:0] pixel_y;
        logic [23:0]        color;
        logic               last_pixel;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/clipped_alpha_blend_blitter.sv
// Pipeline: an accepted item is offered on the output once it has passed both
// registers (two-register pipeline: input register, result register).
// Throughput: one item per cycle while the output is not stalled; stalls back up through both registers.
// Reset: config registers to defaults, icon counters to zero, pipeline empty.
// Top level of the clipped alpha blend blitter; uses cab_blit_pkg.
`default_nettype none

module clipped_alpha_blend_blitter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire cab_blit_pkg::in_item_t                 in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output cab_blit_pkg::out_item_t                     out_data,
    input  wire logic                                   cfg_write,
    input  wire logic [cab_blit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [cab_blit_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cab_blit_pkg::*;

    localparam int CMP_BITS = (CNT_BITS + 1 > SIDE_BITS) ? CNT_BITS + 1 : SIDE_BITS;

    // (s*a + d*(255-a)) / 255, division done as (x + (x>>8) + 1) >> 8
    function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
        logic [15:0] num;
        logic [16:0] t;
        num = ({8'd0, s} * {8'd0, a}) + ({8'd0, d} * {8'd0, ~a});
        t   = {1'b0, num} + {9'd0, num[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // configuration
    logic [POS_BITS-1:0]  origin_x_reg, origin_y_reg;
    logic [SIDE_BITS-1:0] icon_side_reg;
    logic [POS_BITS-1:0]  frame_width_reg, frame_height_reg;

    // icon counters
    logic [CNT_BITS-1:0] col_reg, col_next;
    logic [CNT_BITS-1:0] row_reg, row_next;

    // stage 1: input register
    logic                s1_valid_reg, s1_valid_next;
    in_item_t            s1_data_reg;
    logic [CNT_BITS-1:0] s1_col_reg, s1_row_reg;
    logic                s1_last_reg;

    // stage 2: result register
    logic                s2_valid_reg, s2_valid_next;
    out_item_t           s2_data_reg, s2_data_next;

    logic                in_accept, s2_ready, s1_advance;
    logic [SIDE_BITS-1:0] side_eff;
    logic [CMP_BITS-1:0] col_inc, row_inc, side_cmp;
    logic                end_col, end_row;
    logic [POS_BITS-1:0] fw_lim, fh_lim;
    logic [POS_BITS:0]   px, py;
    logic                in_frame, we;
    logic [7:0]          alpha;
    logic [23:0]         color;

    assign s2_ready   = !s2_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && s2_ready;
    assign in_stall   = s1_valid_reg && !s2_ready;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = s2_valid_reg;
    assign out_data   = s2_data_reg;

    // effective side and counter wrap
    always_comb
    begin
        if (icon_side_reg == '0)
            side_eff = SIDE_BITS'(1);
        else if (int'(icon_side_reg) > MAX_ICON_SIDE)
            side_eff = SIDE_BITS'(MAX_ICON_SIDE);
        else
            side_eff = icon_side_reg;
        col_inc  = CMP_BITS'(col_reg) + CMP_BITS'(1);
        row_inc  = CMP_BITS'(row_reg) + CMP_BITS'(1);
        side_cmp = CMP_BITS'(side_eff);
        end_col  = col_inc >= side_cmp;
        end_row  = row_inc >= side_cmp;

        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_inc[CNT_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_BITS-1:0];
            end
        end
    end

    // clip and blend on the stage 1 item
    always_comb
    begin
        fw_lim = (int'(frame_width_reg) > FRAME_TOP) ? POS_BITS'(FRAME_TOP) : frame_width_reg;
        fh_lim = (int'(frame_height_reg) > FRAME_TOP) ? POS_BITS'(FRAME_TOP) : frame_height_reg;
        px = {origin_x_reg[POS_BITS-1], origin_x_reg} + (POS_BITS+1)'(s1_col_reg);
        py = {origin_y_reg[POS_BITS-1], origin_y_reg} + (POS_BITS+1)'(s1_row_reg);
        in_frame = !px[POS_BITS] && !py[POS_BITS] &&
                   (px[POS_BITS-1:0] < fw_lim) && (py[POS_BITS-1:0] < fh_lim);
        alpha = s1_data_reg.source_pixel[31:24];
        we    = in_frame && (alpha != 8'd0);

        if (!we)
            color = '0;
        else if (alpha == ALPHA_OPAQUE)
            color = s1_data_reg.source_pixel[23:0];
        else
            color = {blend_ch(s1_data_reg.source_pixel[23:16],
                              s1_data_reg.dest_pixel[23:16], alpha),
                     blend_ch(s1_data_reg.source_pixel[15:8],
                              s1_data_reg.dest_pixel[15:8], alpha),
                     blend_ch(s1_data_reg.source_pixel[7:0],
                              s1_data_reg.dest_pixel[7:0], alpha)};

        s2_data_next.write_enable = we;
        s2_data_next.pixel_x      = we ? px[XY_BITS-1:0] : '0;
        s2_data_next.pixel_y      = we ? py[XY_BITS-1:0] : '0;
        s2_data_next.color        = color;
        s2_data_next.last_pixel   = s1_last_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            icon_side_reg    <= ICON_SIDE_RESET;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                CFG_ICON_SIDE:    icon_side_reg    <= cfg_data[SIDE_BITS-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_data;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= end_col && end_row;
        end
        if (s1_advance)
            s2_data_reg <= s2_data_next;
    end

    // a skipped pixel carries no position or color
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.write_enable) |->
            (out_data.pixel_x == '0 && out_data.pixel_y == '0 && out_data.color == '0))
        else $error("skipped pixel with nonzero payload");

    // the last pixel of the icon returns both counters to the start
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_col && end_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after last pixel");

    // input stalls only when both registers are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("input stalled with room in pipeline");

    // an item moving out of stage 1 shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid)
        else $error("item lost between stages");

endmodule

`default_nettype wire

// File: sim/blit_pixel_checker.sv
`timescale 1ns / 100ps
// Watches both channels and the register port of the blitter and keeps its own
// copy of the registers and icon counters. Depends on cab_blit_pkg only.
module blit_pixel_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  cab_blit_pkg::in_item_t                  in_data,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  cab_blit_pkg::out_item_t                 out_data,
    input  logic                                    cfg_write,
    input  logic [cab_blit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cab_blit_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                      fail_count,
    output int                                      pending
);
    import cab_blit_pkg::*;

    localparam int REPORT_LIMIT = 40;

    logic [POS_BITS-1:0]  org_x;
    logic [POS_BITS-1:0]  org_y;
    logic [SIDE_BITS-1:0] side_reg;
    logic [POS_BITS-1:0]  width_reg;
    logic [POS_BITS-1:0]  height_reg;
    int                   col;
    int                   row;
    out_item_t            expected_writes[$];

    function automatic int mix_channel(int s, int d, int a);
        return (s * a + d * (255 - a)) / 255;
    endfunction

    // frame write for one icon pixel at icon position (c, r)
    function automatic out_item_t place_pixel(in_item_t item, int c, int r);
        out_item_t res;
        int x;
        int y;
        int w;
        int h;
        int a;
        w = (width_reg > FRAME_TOP) ? FRAME_TOP : int'(width_reg);
        h = (height_reg > FRAME_TOP) ? FRAME_TOP : int'(height_reg);
        x = int'($signed(org_x)) + c;
        y = int'($signed(org_y)) + r;
        a = int'(item.source_pixel[31:24]);
        res = '0;
        res.write_enable = (x >= 0 && y >= 0 && x < w && y < h && a != 0);
        if (res.write_enable) begin
            res.pixel_x = x[XY_BITS-1:0];
            res.pixel_y = y[XY_BITS-1:0];
            if (a == int'(ALPHA_OPAQUE)) begin
                res.color = item.source_pixel[23:0];
            end else begin
                for (int ch = 0; ch < 3; ch++) begin
                    res.color[8*ch +: 8] = 8'(mix_channel(int'(item.source_pixel[8*ch +: 8]),
                                                          int'(item.dest_pixel[8*ch +: 8]), a));
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        int side_n;
        if (!rst_n) begin
            org_x      = '0;
            org_y      = '0;
            side_reg   = ICON_SIDE_RESET;
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            col        = 0;
            row        = 0;
            expected_writes.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_ORIGIN_X:     org_x = cfg_data;
                    CFG_ORIGIN_Y:     org_y = cfg_data;
                    CFG_ICON_SIDE:    side_reg = cfg_data[SIDE_BITS-1:0];
                    CFG_FRAME_WIDTH:  width_reg = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: blit result with no pixel pending: ", $time,
                                 "we=%0d x=%0d y=%0d color=%06h last=%0d",
                                 out_data.write_enable, out_data.pixel_x,
                                 out_data.pixel_y, out_data.color, out_data.last_pixel);
                end else begin
                    want = expected_writes.pop_front();
                    if (out_data.write_enable !== want.write_enable ||
                        out_data.pixel_x !== want.pixel_x ||
                        out_data.pixel_y !== want.pixel_y ||
                        out_data.color !== want.color ||
                        out_data.last_pixel !== want.last_pixel) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: blit mismatch: ", $time,
                                     "expected we=%0d x=%0d y=%0d color=%06h last=%0d, ",
                                     want.write_enable, want.pixel_x, want.pixel_y,
                                     want.color, want.last_pixel,
                                     "got we=%0d x=%0d y=%0d color=%06h last=%0d",
                                     out_data.write_enable, out_data.pixel_x,
                                     out_data.pixel_y, out_data.color,
                                     out_data.last_pixel);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                side_n = int'(side_reg);
                if (side_n == 0)
                    side_n = 1;
                if (side_n > MAX_ICON_SIDE)
                    side_n = MAX_ICON_SIDE;
                want = place_pixel(in_data, col, row);
                // counters left past a lowered side end the row / icon at once
                want.last_pixel = (col + 1 >= side_n) && (row + 1 >= side_n);
                expected_writes.push_back(want);
                if (col + 1 >= side_n) begin
                    col = 0;
                    row = (row + 1 >= side_n) ? 0 : row + 1;
                end else begin
                    col = col + 1;
                end
            end
        end
        pending = expected_writes.size();
    end

endmodule

// File: sim/clipped_alpha_blend_blitter_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the clipped alpha blend blitter; the checking is
// done by blit_pixel_checker. Depends on cab_blit_pkg and the block itself.
module clipped_alpha_blend_blitter_tb;
    import cab_blit_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int CALM_ITEMS     = 150;
    localparam int HOLD_CYCLES    = 48;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 3'd5;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_item_t                  in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int   fail_count;
    int   pending;
    int   quiet = 0;
    int   sent = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    always #6 clk = ~clk;

    clipped_alpha_blend_blitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blit_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // receiver: random stall bursts, one long hold on request, none when calm
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
        end
    end

    function automatic in_item_t pixel(logic [31:0] s, logic [23:0] d);
        in_item_t p;
        p.source_pixel = s;
        p.dest_pixel   = d;
        return p;
    endfunction

    function automatic in_item_t rand_pixel();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(0, 5))
            0: s[31:24] = 8'h00;
            1: s[31:24] = ALPHA_OPAQUE;
            default: ;
        endcase
        return pixel(s, 24'($urandom));
    endfunction

    function automatic int pick_extent();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return FRAME_TOP;
            3: return 8191;
            4: return int'($urandom_range(FRAME_TOP + 1, 8191));
            default: return int'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic int pick_origin(int extent, int side);
        int edge_pos;
        edge_pos = (extent > FRAME_TOP) ? FRAME_TOP : extent;
        case ($urandom_range(0, 6))
            0: return -4096;
            1: return 4095;
            2: return int'($urandom_range(0, 8191)) - 4096;
            3: return 0 - int'($urandom_range(0, side));
            4: return edge_pos - int'($urandom_range(0, side));
            default: return int'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic send_pixel(in_item_t item);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_pixels(int count, logic gaps);
        for (int i = 0; i < count; i++) begin
            send_pixel(rand_pixel());
            if (gaps && !calm && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 6));
        end
        sent += count;
    endtask

    task automatic pick_setup();
        int w;
        int h;
        int s;
        w = pick_extent();
        h = pick_extent();
        case ($urandom_range(0, 9))
            0: s = 0;
            1: s = 127;
            2: s = MAX_ICON_SIDE;
            3: s = int'($urandom_range(65, 127));
            default: s = int'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_FRAME_WIDTH, w);
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_FRAME_HEIGHT, h);
        if ($urandom_range(0, 3) != 0) begin
            // upper data bits beyond the side field are don't-care
            if ($urandom_range(0, 3) == 0)
                s = s | (int'($urandom_range(0, 63)) << SIDE_BITS);
            write_reg(CFG_ICON_SIDE, s);
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_ORIGIN_X, pick_origin(w, s & 8'h7F));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_ORIGIN_Y, pick_origin(h, s & 8'h7F));
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNMAPPED + 3'($urandom_range(0, 2)), int'($urandom_range(0, 8191)));
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: alpha extremes, copy, blend rounding
        send_pixel(pixel(32'h00FFFFFF, 24'h123456));
        send_pixel(pixel(32'hFFFFFFFF, 24'h000000));
        send_pixel(pixel(32'hFF000000, 24'hFFFFFF));
        send_pixel(pixel(32'h01FFFFFF, 24'h000000));
        send_pixel(pixel(32'hFE000000, 24'hFFFFFF));
        send_pixel(pixel(32'h80A5C35A, 24'h5A3CA5));
        send_pixel(pixel(32'h7F0F0F0F, 24'hF0F0F0));
        send_pixel(pixel(32'h00000000, 24'h000000));
        send_pixel(pixel(32'hFFA5A5A5, 24'hFFFFFF));
        wait_idle();

        // side lowered mid-icon, icon at the far corner of a full frame
        write_reg(CFG_ICON_SIDE, 2);
        write_reg(CFG_ORIGIN_X, 4094);
        write_reg(CFG_ORIGIN_Y, 4094);
        write_reg(CFG_FRAME_WIDTH, FRAME_TOP);
        write_reg(CFG_FRAME_HEIGHT, FRAME_TOP);
        run_pixels(6, 1'b0);
        wait_idle();

        // side zero acts as one; then a zero-size frame clips everything
        write_reg(CFG_ICON_SIDE, 0);
        write_reg(CFG_ORIGIN_X, 0);
        write_reg(CFG_ORIGIN_Y, 0);
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 1);
        write_reg(CFG_UNMAPPED, 8191);
        send_pixel(pixel(32'hFF123456, 24'h654321));
        send_pixel(pixel(32'h40FEDCBA, 24'h0F1E2D));
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 0);
        send_pixel(pixel(32'hFFFFFFFF, 24'hFFFFFF));
        send_pixel(pixel(32'h80808080, 24'h808080));
        wait_idle();

        // oversized side and frame saturate
        write_reg(CFG_ICON_SIDE, 127);
        write_reg(CFG_FRAME_WIDTH, 8191);
        write_reg(CFG_FRAME_HEIGHT, 5000);
        write_reg(CFG_ORIGIN_X, 4095);
        write_reg(CFG_ORIGIN_Y, 4095);
        run_pixels(3, 1'b0);
        wait_idle();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent > RANDOM_ITEMS - CALM_ITEMS);
            pick_setup();
            if (phase == 3) begin
                // long receiver hold while the sender keeps offering
                hold_req = 1'b1;
                run_pixels(40, 1'b0);
            end else begin
                run_pixels($urandom_range(4, 90), $urandom_range(0, 3) != 0);
            end
            wait_idle();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
